[hdl/c2p_pkg.sv]
`default_nettype none

package c2p_pkg;

	// Field widths and precision
	localparam int COORD_BITS    = 12;
	localparam int CORDIC_STAGES = 16;
	localparam int ANGLE_BITS    = 16;
	localparam int HUE_BITS      = 8;

	// Register indexes on the configuration port (byte address is 4 * index)
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Fixed-point layout of the rotation datapath
	localparam int GUARD_BITS = 20;
	localparam int OFF_W      = COORD_BITS + 1;
	localparam int V_W        = COORD_BITS + GUARD_BITS + 4;
	localparam int ACC_W      = 32;
	localparam int ANGLE_DROP = ACC_W - ANGLE_BITS;

	// Digit-by-digit square root: one result bit per cell
	localparam int SQRT_STEPS = COORD_BITS + 1;
	localparam int RAD_W      = 2 * SQRT_STEPS;
	localparam int REM_W      = SQRT_STEPS + 1;

	// Chain covers both the rotations and the root digits
	localparam int CHAIN_LEN = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
	localparam int IDX_W     = $clog2(CHAIN_LEN + 1);

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t CORDIC_CNT = IDX_W'(CORDIC_STAGES);
	localparam idx_t SQRT_CNT   = IDX_W'(SQRT_STEPS);

	// Turn fractions on the 32-bit accumulator
	localparam logic [ACC_W-1:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [ACC_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [ACC_W-1:0] TQ_TURN      = 32'hC000_0000;
	localparam logic [ACC_W-1:0] ROUND_HALF   = ACC_W'(1) << (ANGLE_DROP - 1);

	// Data handed from cell to cell
	typedef struct packed {
		logic signed [OFF_W-1:0] ox;
		logic signed [OFF_W-1:0] oy;
		logic signed [V_W-1:0]   vx;
		logic signed [V_W-1:0]   vy;
		logic [ACC_W-1:0]        acc;
		logic                    hold;
		logic [RAD_W-1:0]        rad;
		logic [REM_W-1:0]        rem;
		logic [SQRT_STEPS-1:0]   root;
	} cell_t;

	// atan(2^-i) as a fraction of a turn, 2^32 per turn
	function automatic logic [ACC_W-1:0] atan_turn(input idx_t i);
		logic [ACC_W-1:0] r;
		case (i)
			5'd0:    r = 32'h2000_0000;
			5'd1:    r = 32'h12E4_051E;
			5'd2:    r = 32'h09FB_385B;
			5'd3:    r = 32'h0511_11D4;
			5'd4:    r = 32'h028B_0D43;
			5'd5:    r = 32'h0145_D7E1;
			5'd6:    r = 32'h00A2_F61E;
			5'd7:    r = 32'h0051_7C55;
			5'd8:    r = 32'h0028_BE53;
			5'd9:    r = 32'h0014_5F2F;
			5'd10:   r = 32'h000A_2F98;
			5'd11:   r = 32'h0005_17CC;
			5'd12:   r = 32'h0002_8BE6;
			5'd13:   r = 32'h0001_45F3;
			5'd14:   r = 32'h0000_A2FA;
			5'd15:   r = 32'h0000_517D;
			5'd16:   r = 32'h0000_28BE;
			5'd17:   r = 32'h0000_145F;
			5'd18:   r = 32'h0000_0A30;
			5'd19:   r = 32'h0000_0518;
			5'd20:   r = 32'h0000_028C;
			5'd21:   r = 32'h0000_0146;
			5'd22:   r = 32'h0000_00A3;
			5'd23:   r = 32'h0000_0051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/c2p_if.sv]
`default_nettype none

// Pointer position channel
interface c2p_pt_if;
	logic                            valid;
	logic                            ready;
	logic [c2p_pkg::COORD_BITS-1:0]  pointer_x;
	logic [c2p_pkg::COORD_BITS-1:0]  pointer_y;

	modport source(output valid, output pointer_x, output pointer_y, input ready);
	modport sink(input valid, input pointer_x, input pointer_y, output ready);
endinterface

// Polar result channel
interface c2p_polar_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [c2p_pkg::OFF_W-1:0]     offset_x;
	logic signed [c2p_pkg::OFF_W-1:0]     offset_y;
	logic [c2p_pkg::OFF_W-1:0]            radius;
	logic [c2p_pkg::ANGLE_BITS-1:0]       angle;
	logic [c2p_pkg::HUE_BITS-1:0]         hue;

	modport source(output valid, output offset_x, output offset_y, output radius,
		output angle, output hue, input ready);
	modport sink(input valid, input offset_x, input offset_y, input radius,
		input angle, input hue, output ready);
endinterface

`default_nettype wire

[hdl/cartesian_to_polar_hue.sv]
`default_nettype none

// Channel  Dir  Beat payload
// -------  ---  -------------------------------------------------------
// pointer  in   pointer_x, pointer_y (screen pixels)
// polar    out  offset_x, offset_y, radius, angle (turn), hue
// apb      cfg  reg 0 screen_width @0x0, reg 1 screen_height @0x4
//
// One beat per cycle sustained while polar.ready is taken; the path runs through the front stages,
// the row of rotation/root cells, one cell per CORDIC stage, and the back stages.
// Every stage has its own valid bit and moves when the one after it is empty
// or moving, so bubbles close up and input is taken while a result waits.
// Reset clears all valid bits and loads width 1024, height 768.

module cartesian_to_polar_hue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	c2p_pt_if.sink            pointer,
	c2p_polar_if.source       polar,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output      logic [31:0]  prdata,
	output      logic         pready
);

	localparam logic [c2p_pkg::ANGLE_BITS-1:0] ANG_QUARTER =
		c2p_pkg::ANGLE_BITS'(1) << (c2p_pkg::ANGLE_BITS - 2);

	logic [c2p_pkg::OFF_W-1:0]  width_q, height_q;
	logic                       cfg_wr;

	logic                       chain_v   [c2p_pkg::CHAIN_LEN+1];
	logic                       chain_rdy [c2p_pkg::CHAIN_LEN+1];
	c2p_pkg::cell_t             chain_d   [c2p_pkg::CHAIN_LEN+1];

	logic signed [31:0]         chk_ox, chk_oy, chk_r, chk_sq;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= c2p_pkg::OFF_W'(1024);
			height_q <= c2p_pkg::OFF_W'(768);
		end else if (cfg_wr) begin
			case (paddr[2])
				c2p_pkg::REG_WIDTH:  width_q  <= pwdata[c2p_pkg::OFF_W-1:0];
				c2p_pkg::REG_HEIGHT: height_q <= pwdata[c2p_pkg::OFF_W-1:0];
				default:             ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			c2p_pkg::REG_WIDTH:  prdata = 32'(width_q);
			c2p_pkg::REG_HEIGHT: prdata = 32'(height_q);
			default:             prdata = '0;
		endcase
	end

	// Offsets and vector setup
	c2p_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pointer   (pointer),
		.cx        (width_q[c2p_pkg::OFF_W-1:1]),
		.cy        (height_q[c2p_pkg::OFF_W-1:1]),
		.out_valid (chain_v[0]),
		.out_ready (chain_rdy[0]),
		.out_data  (chain_d[0])
	);

	// Row of rotation/root cells
	for (genvar g = 0; g < c2p_pkg::CHAIN_LEN; g++) begin : g_cell
		c2p_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (c2p_pkg::IDX_W'(g)),
			.in_valid  (chain_v[g]),
			.in_ready  (chain_rdy[g]),
			.in_data   (chain_d[g]),
			.out_valid (chain_v[g+1]),
			.out_ready (chain_rdy[g+1]),
			.out_data  (chain_d[g+1])
		);
	end

	// Rounding, hue and output register
	c2p_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_v[c2p_pkg::CHAIN_LEN]),
		.in_ready (chain_rdy[c2p_pkg::CHAIN_LEN]),
		.in_data  (chain_d[c2p_pkg::CHAIN_LEN]),
		.polar    (polar)
	);

	// Check values for the radius bounds
	assign chk_ox = 32'(polar.offset_x);
	assign chk_oy = 32'(polar.offset_y);
	assign chk_r  = 32'(polar.radius);
	assign chk_sq = chk_ox * chk_ox + chk_oy * chk_oy;

	a_radius_floor: assert property (@(posedge clk) disable iff (!arst_n)
		polar.valid |-> (chk_r * chk_r <= chk_sq) && ((chk_r + 1) * (chk_r + 1) > chk_sq))
		else $error("radius is not the floor of the distance");

	a_origin_angle: assert property (@(posedge clk) disable iff (!arst_n)
		polar.valid && polar.offset_x == '0 && polar.offset_y == '0
		|-> polar.angle == '0 && polar.hue == '0 && polar.radius == '0)
		else $error("origin result is not zero");

	a_up_axis: assert property (@(posedge clk) disable iff (!arst_n)
		polar.valid && polar.offset_x == '0 && polar.offset_y[c2p_pkg::OFF_W-1]
		|-> polar.angle == ANG_QUARTER)
		else $error("straight up is not a quarter turn");

	a_right_axis: assert property (@(posedge clk) disable iff (!arst_n)
		polar.valid && polar.offset_y == '0 && polar.offset_x != '0
		&& !polar.offset_x[c2p_pkg::OFF_W-1]
		|-> polar.angle == '0)
		else $error("positive x axis is not angle zero");

endmodule

`default_nettype wire

[hdl/c2p_front.sv]
`default_nettype none

module c2p_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	c2p_pt_if.sink                                pointer,
	input  wire logic [c2p_pkg::COORD_BITS-1:0]   cx,
	input  wire logic [c2p_pkg::COORD_BITS-1:0]   cy,
	output      logic                             out_valid,
	input  wire logic                             out_ready,
	output      c2p_pkg::cell_t                   out_data
);

	logic                                v_s1, v_s2;
	logic signed [c2p_pkg::OFF_W-1:0]    ox_s1, oy_s1;
	c2p_pkg::cell_t                      prep_s2;
	logic                                rdy_s1, rdy_s2;
	logic signed [c2p_pkg::OFF_W-1:0]    ox_d, oy_d;
	logic signed [c2p_pkg::OFF_W-1:0]    ax_w, ay_w;
	logic [c2p_pkg::COORD_BITS-1:0]      ax, ay;
	logic signed [c2p_pkg::V_W-1:0]      vx0, vy0, vx1, vy1;
	c2p_pkg::cell_t                      prep_d;

	assign rdy_s2        = !v_s2 || out_ready;
	assign rdy_s1        = !v_s1 || rdy_s2;
	assign pointer.ready = rdy_s1;
	assign out_valid     = v_s2;
	assign out_data      = prep_s2;

	// Subtract the screen centre
	assign ox_d = $signed({1'b0, pointer.pointer_x}) - $signed({1'b0, cx});
	assign oy_d = $signed({1'b0, pointer.pointer_y}) - $signed({1'b0, cy});

	// Prepare the vector: flip y, fold the left half plane, scale, square sum
	always_comb begin
		ax_w = ox_s1[c2p_pkg::OFF_W-1] ? -ox_s1 : ox_s1;
		ay_w = oy_s1[c2p_pkg::OFF_W-1] ? -oy_s1 : oy_s1;
		ax   = ax_w[c2p_pkg::COORD_BITS-1:0];
		ay   = ay_w[c2p_pkg::COORD_BITS-1:0];
		vx0  = c2p_pkg::V_W'(ox_s1);
		vy0  = -c2p_pkg::V_W'(oy_s1);
		prep_d = '0;
		prep_d.ox = ox_s1;
		prep_d.oy = oy_s1;
		if (ox_s1[c2p_pkg::OFF_W-1]) begin
			vx1 = -vx0;
			vy1 = -vy0;
			prep_d.acc = c2p_pkg::HALF_TURN;
		end else begin
			vx1 = vx0;
			vy1 = vy0;
			prep_d.acc = '0;
		end
		prep_d.vx = vx1 <<< c2p_pkg::GUARD_BITS;
		prep_d.vy = vy1 <<< c2p_pkg::GUARD_BITS;
		// Axes and origin take exact angles
		prep_d.hold = (ox_s1 == '0) || (oy_s1 == '0);
		if (ox_s1 == '0 && oy_s1 == '0) begin
			prep_d.acc = '0;
		end else if (ox_s1 == '0) begin
			prep_d.acc = oy_s1[c2p_pkg::OFF_W-1] ? c2p_pkg::QUARTER_TURN : c2p_pkg::TQ_TURN;
		end else if (oy_s1 == '0) begin
			prep_d.acc = ox_s1[c2p_pkg::OFF_W-1] ? c2p_pkg::HALF_TURN : '0;
		end
		prep_d.rad = c2p_pkg::RAD_W'(ax) * c2p_pkg::RAD_W'(ax)
			+ c2p_pkg::RAD_W'(ay) * c2p_pkg::RAD_W'(ay);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= pointer.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Payload, advance only on a real beat
	always_ff @(posedge clk) begin
		if (rdy_s1 && pointer.valid) begin
			ox_s1 <= ox_d;
			oy_s1 <= oy_d;
		end
		if (rdy_s2 && v_s1) begin
			prep_s2 <= prep_d;
		end
	end

endmodule

`default_nettype wire

[hdl/c2p_cell.sv]
`default_nettype none

module c2p_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire c2p_pkg::idx_t   idx,
	input  wire logic            in_valid,
	output      logic            in_ready,
	input  wire c2p_pkg::cell_t  in_data,
	output      logic            out_valid,
	input  wire logic            out_ready,
	output      c2p_pkg::cell_t  out_data
);

	logic                              v_s1;
	c2p_pkg::cell_t                    d_s1;
	c2p_pkg::cell_t                    nxt;
	logic signed [c2p_pkg::V_W-1:0]    vx, vy, dx, dy;
	logic [c2p_pkg::REM_W+1:0]         rem_sh, trial;
	logic                              cordic_on, sqrt_on;

	assign in_ready  = !v_s1 || out_ready;
	assign out_valid = v_s1;
	assign out_data  = d_s1;
	assign cordic_on = idx < c2p_pkg::CORDIC_CNT;
	assign sqrt_on   = idx < c2p_pkg::SQRT_CNT;

	// One micro-rotation (cells below CORDIC_CNT) and one root digit (cells below SQRT_CNT)
	always_comb begin
		nxt    = in_data;
		vx     = in_data.vx;
		vy     = in_data.vy;
		dx     = vx >>> idx;
		dy     = vy >>> idx;
		rem_sh = {in_data.rem, in_data.rad[c2p_pkg::RAD_W-1 -: 2]};
		trial  = {1'b0, in_data.root, 2'b01};
		if (cordic_on) begin
			if (!vy[c2p_pkg::V_W-1]) begin
				nxt.vx = vx + dy;
				nxt.vy = vy - dx;
				if (!in_data.hold) begin
					nxt.acc = in_data.acc + c2p_pkg::atan_turn(idx);
				end
			end else begin
				nxt.vx = vx - dy;
				nxt.vy = vy + dx;
				if (!in_data.hold) begin
					nxt.acc = in_data.acc - c2p_pkg::atan_turn(idx);
				end
			end
		end
		if (sqrt_on) begin
			nxt.rad = {in_data.rad[c2p_pkg::RAD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				nxt.rem  = c2p_pkg::REM_W'(rem_sh - trial);
				nxt.root = {in_data.root[c2p_pkg::SQRT_STEPS-2:0], 1'b1};
			end else begin
				nxt.rem  = rem_sh[c2p_pkg::REM_W-1:0];
				nxt.root = {in_data.root[c2p_pkg::SQRT_STEPS-2:0], 1'b0};
			end
		end
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

[hdl/c2p_back.sv]
`default_nettype none

module c2p_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output      logic            in_ready,
	input  wire c2p_pkg::cell_t  in_data,
	c2p_polar_if.source          polar
);

	localparam int PROD_W = c2p_pkg::ANGLE_BITS + c2p_pkg::HUE_BITS;

	logic                                  v_s1, v_s2;
	logic                                  rdy_s1, rdy_s2;
	logic signed [c2p_pkg::OFF_W-1:0]      ox_s1, oy_s1, ox_s2, oy_s2;
	logic [c2p_pkg::OFF_W-1:0]             rad_s1, rad_s2;
	logic [c2p_pkg::ANGLE_BITS-1:0]        angle_s1, angle_s2;
	logic [c2p_pkg::HUE_BITS-1:0]          hue_s2;
	logic [c2p_pkg::ACC_W-1:0]             rsum;
	logic [PROD_W-1:0]                     prod;

	assign rdy_s2   = !v_s2 || polar.ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Round the turn fraction, wrap a full turn to zero
	assign rsum = in_data.acc + c2p_pkg::ROUND_HALF;

	// angle * 255 as a shift and subtract
	assign prod = {angle_s1, {c2p_pkg::HUE_BITS{1'b0}}} - PROD_W'(angle_s1);

	assign polar.valid    = v_s2;
	assign polar.offset_x = ox_s2;
	assign polar.offset_y = oy_s2;
	assign polar.radius   = rad_s2;
	assign polar.angle    = angle_s2;
	assign polar.hue      = hue_s2;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Payload; the output register holds a beat until it is taken
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			ox_s1    <= in_data.ox;
			oy_s1    <= in_data.oy;
			rad_s1   <= in_data.root;
			angle_s1 <= rsum[c2p_pkg::ACC_W-1:c2p_pkg::ANGLE_DROP];
		end
		if (rdy_s2 && v_s1) begin
			ox_s2    <= ox_s1;
			oy_s2    <= oy_s1;
			rad_s2   <= rad_s1;
			angle_s2 <= angle_s1;
			hue_s2   <= prod[PROD_W-1 -: c2p_pkg::HUE_BITS];
		end
	end

endmodule

`default_nettype wire
